// ----- hdl/range_copy_overlay_table_macros.svh -----
// ----------------------------------------------------------------------------
// Range copy overlay table: assertion macros
// Concurrent checks clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RANGE_COPY_OVERLAY_TABLE_MACROS_SVH
`define RANGE_COPY_OVERLAY_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define RCOT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rcot assertion failed");
`define RCOT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rcot forbidden condition seen");
`else
`define RCOT_ASSERT(lbl, prop)
`define RCOT_NEVER(lbl, cond)
`endif

`endif

// ----- hdl/rcot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_pkg
// Shared types, codes and defaults of the range copy overlay table.
// ----------------------------------------------------------------------------
package rcot_pkg;

  localparam int unsigned EntriesDflt   = 1024;
  localparam int unsigned CopySlotsDflt = 1024;
  localparam int unsigned DataWidthDflt = 32;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdxFldW = 10;
  localparam int unsigned LenFldW = 11;
  localparam int unsigned ValFldW = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 40;

  localparam logic [LenFldW-1:0] LenReset = 11'd1024;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_SRC  = 2'd0,
    CMD_LOAD_BASE = 2'd1,
    CMD_COPY      = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_RSVD  = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ASSIGN,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_LOOK,
    ST_ADDR,
    ST_DATA,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic check;
    logic load_wr;
    logic copy_start;
    logic walk_start;
    logic asg_left;
    logic asg_right;
    logic asg_up;
    logic walk_rd;
    logic walk_acc;
    logic look;
    logic addr_rd;
    logic data_cap;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic range_err;
    logic full;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic node_root;
    logic stamp_zero;
    logic clr_last;
  } dp_stat_t;

endpackage

// ----- hdl/rcot_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_datapath
// Stores, copy tables, stamp tree, range checks and result register.
// ----------------------------------------------------------------------------
module rcot_datapath import rcot_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDflt,
  parameter int unsigned COPY_SLOTS = CopySlotsDflt,
  parameter int unsigned DATA_WIDTH = DataWidthDflt
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LenFldW-1:0]   cfg_len_i,
  input  cmd_e                 in_cmd_i,
  input  logic [IdxFldW-1:0]   in_tgt_i,
  input  logic [IdxFldW-1:0]   in_src_i,
  input  logic [LenFldW-1:0]   in_len_i,
  input  logic [ValFldW-1:0]   in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic [ValFldW-1:0]   out_value_o,
  output logic [StatW-1:0]     out_status_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODE_W = IDX_W + 1;
  localparam int unsigned CMP_W  = (IDX_W + 3 > 13) ? IDX_W + 3 : 13;
  localparam int unsigned CNT_W  = $clog2(COPY_SLOTS + 1);
  localparam int unsigned SLOT_W = (COPY_SLOTS > 1) ? $clog2(COPY_SLOTS) : 1;

  logic [DATA_WIDTH-1:0] src_mem  [ENTRIES];
  logic [DATA_WIDTH-1:0] base_mem [ENTRIES];
  logic [IDX_W-1:0]      csrc_mem [COPY_SLOTS];
  logic [IDX_W-1:0]      cdst_mem [COPY_SLOTS];
  logic [CNT_W-1:0]      tree_mem [2*LEAVES];

  cmd_e                  cmd_q;
  logic [CMP_W-1:0]      tgt_q, src_q, len_q;
  logic [ValFldW-1:0]    data_q;
  logic [LenFldW-1:0]    cfg_len_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [NODE_W-1:0]     clr_q;
  logic [NODE_W:0]       l_q, r_q;
  logic [NODE_W-1:0]     node_q;
  logic [CNT_W-1:0]      acc_q, tree_rd_q;
  logic                  use_src_q;
  logic [IDX_W-1:0]      csrc_rd_q, cdst_rd_q;
  logic [DATA_WIDTH-1:0] src_rd_q, base_rd_q;
  logic [StatW-1:0]      status_q, out_status_q;
  logic [ValFldW-1:0]    result_q, out_value_q;

  logic [CMP_W-1:0]      n_eff, at_full;
  logic                  range_err, full;
  logic [IDX_W-1:0]      tgt_idx, at_idx;
  logic [SLOT_W-1:0]     slot_wr, slot_rd;
  logic [CNT_W-1:0]      stamp_m1;
  logic [63:0]           data_wide, src_wide, base_wide;
  logic [DATA_WIDTH-1:0] data_st;
  logic                  tree_we;
  logic [NODE_W-1:0]     tree_wa;
  logic [CNT_W-1:0]      tree_wd;
  logic [NODE_W:0]       r_m1;

  always_comb begin
    n_eff = (CMP_W'(cfg_len_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cfg_len_q);
    full  = (cnt_q >= CNT_W'(COPY_SLOTS));
    if (cmd_q == CMD_COPY) begin
      range_err = (len_q == '0) || (tgt_q + len_q > n_eff) || (src_q + len_q > n_eff);
    end else begin
      range_err = (tgt_q >= n_eff);
    end
  end

  assign tgt_idx   = tgt_q[IDX_W-1:0];
  assign slot_wr   = SLOT_W'(cnt_q);
  assign stamp_m1  = acc_q - CNT_W'(1);
  assign slot_rd   = SLOT_W'(stamp_m1);
  // offset within the copy never leaves the array, so no wrap is needed
  assign at_full   = CMP_W'(csrc_rd_q) + tgt_q - CMP_W'(cdst_rd_q);
  assign at_idx    = at_full[IDX_W-1:0];
  assign data_wide = 64'(data_q);
  assign data_st   = data_wide[DATA_WIDTH-1:0];
  assign src_wide  = 64'(src_rd_q);
  assign base_wide = 64'(base_rd_q);
  assign r_m1      = r_q - (NODE_W+1)'(1);

  always_comb begin
    tree_we = 1'b0;
    tree_wa = clr_q;
    tree_wd = '0;
    if (cmd_i.clr_step) begin
      tree_we = 1'b1;
    end else if (cmd_i.asg_left) begin
      tree_we = 1'b1;
      tree_wa = l_q[NODE_W-1:0];
      tree_wd = cnt_q;
    end else if (cmd_i.asg_right) begin
      tree_we = 1'b1;
      tree_wa = r_m1[NODE_W-1:0];
      tree_wd = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[tree_wa] <= tree_wd;
    end
    if (cmd_i.walk_rd) begin
      tree_rd_q <= tree_mem[node_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && cmd_q == CMD_LOAD_SRC) begin
      src_mem[tgt_idx] <= data_st;
    end
    if (cmd_i.addr_rd) begin
      src_rd_q <= src_mem[at_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && cmd_q == CMD_LOAD_BASE) begin
      base_mem[tgt_idx] <= data_st;
    end
    if (cmd_i.look) begin
      base_rd_q <= base_mem[tgt_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_start) begin
      csrc_mem[slot_wr] <= src_q[IDX_W-1:0];
      cdst_mem[slot_wr] <= tgt_idx;
    end
    if (cmd_i.look) begin
      csrc_rd_q <= csrc_mem[slot_rd];
      cdst_rd_q <= cdst_mem[slot_rd];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= LenReset;
      cnt_q     <= '0;
      clr_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_len_q <= cfg_len_i;
      end
      if (cmd_i.copy_start) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q    <= in_cmd_i;
      tgt_q    <= CMP_W'(in_tgt_i);
      src_q    <= CMP_W'(in_src_i);
      len_q    <= CMP_W'(in_len_i);
      data_q   <= in_data_i;
      result_q <= '0;
    end
    if (cmd_i.check) begin
      status_q <= range_err ? STAT_RANGE :
                  ((cmd_q == CMD_COPY) && full) ? STAT_FULL : STAT_OK;
    end
    if (cmd_i.copy_start) begin
      l_q <= (NODE_W+1)'(tgt_q) + (NODE_W+1)'(LEAVES);
      r_q <= (NODE_W+1)'(tgt_q + len_q) + (NODE_W+1)'(LEAVES);
    end
    if (cmd_i.asg_left) begin
      l_q <= l_q + (NODE_W+1)'(1);
    end
    if (cmd_i.asg_right) begin
      r_q <= r_m1;
    end
    if (cmd_i.asg_up) begin
      l_q <= l_q >> 1;
      r_q <= r_q >> 1;
    end
    if (cmd_i.walk_start) begin
      node_q <= NODE_W'(tgt_q) + NODE_W'(LEAVES);
      acc_q  <= '0;
    end
    if (cmd_i.walk_acc) begin
      acc_q  <= (tree_rd_q > acc_q) ? tree_rd_q : acc_q;
      node_q <= node_q >> 1;
    end
    if (cmd_i.look) begin
      use_src_q <= (acc_q != '0);
    end
    if (cmd_i.data_cap) begin
      result_q <= use_src_q ? src_wide[ValFldW-1:0] : base_wide[ValFldW-1:0];
    end
    if (cmd_i.out_load) begin
      out_value_q  <= result_q;
      out_status_q <= status_q;
    end
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.range_err  = range_err;
    stat_o.full       = full;
    stat_o.l_lt_r     = (l_q < r_q);
    stat_o.l_odd      = l_q[0];
    stat_o.r_odd      = r_q[0];
    stat_o.node_root  = (node_q == NODE_W'(1));
    stat_o.stamp_zero = (acc_q == '0);
    stat_o.clr_last   = &clr_q;
  end

  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

// ----- hdl/rcot_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcot_ctrl
// Sequencer: tree clearing, command dispatch, tree walks, result hand-off.
// ----------------------------------------------------------------------------
`include "range_copy_overlay_table_macros.svh"
module rcot_ctrl import rcot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        case (stat_i.cmd)
          CMD_COPY:  state_d = (stat_i.range_err || stat_i.full) ? ST_FIN : ST_ASSIGN;
          CMD_READ:  state_d = stat_i.range_err ? ST_FIN : ST_WALK_RD;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_ASSIGN:   if (!stat_i.l_lt_r) state_d = ST_FIN;
      ST_WALK_RD:  state_d = ST_WALK_ACC;
      ST_WALK_ACC: state_d = stat_i.node_root ? ST_LOOK : ST_WALK_RD;
      ST_LOOK:     state_d = stat_i.stamp_zero ? ST_DATA : ST_ADDR;
      ST_ADDR:     state_d = ST_DATA;
      ST_DATA:     state_d = ST_FIN;
      ST_FIN:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:    cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        case (stat_i.cmd)
          CMD_COPY:  cmd_o.copy_start = !stat_i.range_err && !stat_i.full;
          CMD_READ:  cmd_o.walk_start = !stat_i.range_err;
          default:   cmd_o.load_wr    = !stat_i.range_err;
        endcase
      end
      ST_ASSIGN: begin
        if (stat_i.l_lt_r) begin
          if (stat_i.l_odd) begin
            cmd_o.asg_left = 1'b1;
          end else if (stat_i.r_odd) begin
            cmd_o.asg_right = 1'b1;
          end else begin
            cmd_o.asg_up = 1'b1;
          end
        end
      end
      ST_WALK_RD:  cmd_o.walk_rd  = 1'b1;
      ST_WALK_ACC: cmd_o.walk_acc = 1'b1;
      ST_LOOK:     cmd_o.look     = 1'b1;
      ST_ADDR:     cmd_o.addr_rd  = 1'b1;
      ST_DATA:     cmd_o.data_cap = 1'b1;
      ST_FIN:      cmd_o.out_load = out_free;
      default:     cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RCOT_NEVER(a_no_accept_in_clear, (state_q == ST_CLEAR) && in_ready_o)
  `RCOT_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN))
  `RCOT_ASSERT(a_assign_after_check, (state_q == ST_ASSIGN) |-> ($past(state_q == ST_CHECK) || $past(state_q == ST_ASSIGN)))
  `RCOT_NEVER(a_one_tree_write, cmd_o.asg_left && cmd_o.asg_right)

endmodule

// ----- hdl/range_copy_overlay_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_copy_overlay_table
// Overlay of numbered range copies on a base array, resolved per read.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: target, source, length, data
// m_axis    out  m_axis_tvalid/tready    tdata: read value, status
// cfg       in   cfg_valid_i/cfg_ready_o cfg_data_i: array length
//
// One item at a time. Loads and rejected commands pass from the check state to
// the final state; copies pass through an assign state that writes the stamp
// tree one node or level step at a time; reads walk the tree from leaf to root,
// look up the base store and copy tables, read the source store when a copy
// covers the entry and capture the value. After reset a clearing pass zeroes the tree.
// A result waits in the output register; a stalled output holds the next item
// in its final state until the register frees.
// ----------------------------------------------------------------------------
module range_copy_overlay_table import rcot_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDflt,
  parameter int unsigned COPY_SLOTS = CopySlotsDflt,
  parameter int unsigned DATA_WIDTH = DataWidthDflt
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] target_index, [19:10] source_start, [30:20] copy_length,
  // [62:31] load_data, [63] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [CmdW-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] read_value, [33:32] status, [39:34] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LenFldW-1:0]  cfg_data_i
);

  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  logic [ValFldW-1:0] out_value;
  logic [StatW-1:0]   out_status;

  assign cfg_ready_o = 1'b1;

  rcot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  rcot_datapath #(
    .ENTRIES    (ENTRIES),
    .COPY_SLOTS (COPY_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_len_i    (cfg_data_i),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_tgt_i     (s_axis_tdata[9:0]),
    .in_src_i     (s_axis_tdata[19:10]),
    .in_len_i     (s_axis_tdata[30:20]),
    .in_data_i    (s_axis_tdata[62:31]),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .out_value_o  (out_value),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_status, out_value};

endmodule

// ----- tb/range_copy_overlay_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_copy_overlay_table_checker
// Watches the input, output and length channels of the overlay table, keeps
// its own copy of the stores, copy tables and per-entry copy stamps, and
// compares every output beat against the oldest predicted result.
// ----------------------------------------------------------------------------
module range_copy_overlay_table_checker import rcot_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [CmdW-1:0]     s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [LenFldW-1:0]  cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_count_o
);

  localparam int Entries = EntriesDflt;
  localparam int Slots   = CopySlotsDflt;

  typedef struct packed {
    logic [ValFldW-1:0] value;
    stat_e              status;
  } answer_t;

  logic [ValFldW-1:0] src_mem [Entries];
  logic [ValFldW-1:0] base_mem [Entries];
  logic [IdxFldW-1:0] copy_src [Slots];
  logic [IdxFldW-1:0] copy_dst [Slots];
  int                 entry_stamp [Entries];
  int                 copies_taken;
  int                 length_reg;
  answer_t            answer_q [$];
  int                 fails;

  assign fail_count_o    = fails;
  assign pending_count_o = answer_q.size();

  initial begin
    fails        = 0;
    copies_taken = 0;
    length_reg   = int'(LenReset);
    foreach (entry_stamp[i]) entry_stamp[i] = 0;
  end

  function automatic answer_t resolve_item(cmd_e cmd, int tgt, int src, int len,
                                           logic [ValFldW-1:0] data);
    answer_t a;
    int n;
    int st;
    n = (length_reg > Entries) ? Entries : length_reg;
    a.value  = '0;
    a.status = STAT_OK;
    case (cmd)
      CMD_LOAD_SRC, CMD_LOAD_BASE: begin
        if (tgt >= n) a.status = STAT_RANGE;
        else if (cmd == CMD_LOAD_SRC) src_mem[tgt] = data;
        else base_mem[tgt] = data;
      end
      CMD_COPY: begin
        if (len == 0 || tgt + len > n || src + len > n) begin
          a.status = STAT_RANGE;
        end else if (copies_taken >= Slots) begin
          a.status = STAT_FULL;
        end else begin
          copy_src[copies_taken] = IdxFldW'(src);
          copy_dst[copies_taken] = IdxFldW'(tgt);
          copies_taken++;
          // later copies always carry higher numbers, so overwrite wins
          for (int i = tgt; i < tgt + len; i++) entry_stamp[i] = copies_taken;
        end
      end
      default: begin
        if (tgt >= n) begin
          a.status = STAT_RANGE;
        end else begin
          st = entry_stamp[tgt];
          if (st != 0)
            a.value = src_mem[(copy_src[st-1] + tgt - copy_dst[st-1]) % Entries];
          else
            a.value = base_mem[tgt];
        end
      end
    endcase
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) length_reg = int'(cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        answer_q.push_back(resolve_item(cmd_e'(s_axis_tuser), int'(s_axis_tdata[9:0]),
                                        int'(s_axis_tdata[19:10]),
                                        int'(s_axis_tdata[30:20]),
                                        s_axis_tdata[62:31]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.value  = m_axis_tdata[31:0];
        got.status = stat_e'(m_axis_tdata[33:32]);
        if (answer_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected beat: value %h status %0d", got.value,
                                    got.status);
        end else begin
          want = answer_q.pop_front();
          if (got.value !== want.value || got.status !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                       want.value, got.value, want.status, got.status);
          end
        end
      end
    end
  end

endmodule

// ----- tb/range_copy_overlay_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_copy_overlay_table_tb
// Fills the low part of both arrays, then runs directed and random loads,
// copies and reads over several array lengths, with random gaps on both
// streams. The checker does all the comparing.
// ----------------------------------------------------------------------------
module range_copy_overlay_table_tb import rcot_pkg::*;;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [CmdW-1:0]     s_axis_tuser = CMD_LOAD_SRC;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LenFldW-1:0]  cfg_data_i = '0;
  int                  fail_count;
  int                  pending_count;
  int                  cur_len = 1024;
  bit                  steady = 1'b0;
  int                  quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  range_copy_overlay_table dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i
  );

  range_copy_overlay_table_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  always @(negedge clk_i)
    m_axis_tready <= steady || ($urandom_range(99) >= 22);

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_op(cmd_e cmd, int tgt, int src, int len, logic [31:0] data);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = {1'b0, data, len[10:0], src[9:0], tgt[9:0]};
    s_axis_tvalid = 1'b1;
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
  endtask

  task automatic drain_inputs();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic set_length(int value);
    drain_inputs();
    cfg_data_i  = LenFldW'(value);
    cfg_valid_i = 1'b1;
    #1;
    while (!cfg_ready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_len = (value > 1024) ? 1024 : value;
  endtask

  task automatic random_op();
    int r;
    int tgt;
    int src;
    int len;
    int lim;
    r   = $urandom_range(99);
    tgt = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(cur_len - 1);
    src = $urandom_range(1023);
    len = $urandom_range(2047);
    if (r >= 24 && r < 54 && $urandom_range(99) < 88) begin
      lim = (cur_len > 64 && $urandom_range(9) != 0) ? 64 : cur_len;
      len = $urandom_range(1, lim);
      tgt = $urandom_range(0, cur_len - len);
      src = $urandom_range(0, cur_len - len);
    end
    if (r < 12) send_op(CMD_LOAD_SRC, tgt, src, len, $urandom);
    else if (r < 24) send_op(CMD_LOAD_BASE, tgt, src, len, $urandom);
    else if (r < 54) send_op(CMD_COPY, tgt, src, len, $urandom);
    else send_op(CMD_READ, tgt, src, len, $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_length(2047);
    // random phases stay within the first 64 entries, so only those are filled
    for (int i = 0; i < 64; i++) begin
      send_op(CMD_LOAD_SRC, i, $urandom, $urandom, $urandom);
      send_op(CMD_LOAD_BASE, i, $urandom, $urandom, $urandom);
    end

    // directed
    send_op(CMD_LOAD_SRC, 0, 0, 0, 32'h8000_0000);
    send_op(CMD_LOAD_SRC, 1023, 1023, 2047, 32'h7fff_ffff);
    send_op(CMD_LOAD_BASE, 1023, 0, 0, 32'hffff_ffff);
    send_op(CMD_READ, 1023, 0, 0, 0);
    send_op(CMD_COPY, 0, 0, 1024, 0);
    send_op(CMD_READ, 0, 0, 0, 0);
    send_op(CMD_READ, 1023, 0, 0, 0);
    send_op(CMD_COPY, 0, 0, 0, 0);
    send_op(CMD_COPY, 1, 0, 1024, 0);
    send_op(CMD_COPY, 0, 1, 1024, 0);
    send_op(CMD_COPY, 1023, 0, 1, 0);
    send_op(CMD_COPY, 10, 5, 100, 0);
    send_op(CMD_READ, 10, 0, 0, 0);
    send_op(CMD_READ, 59, 0, 0, 0);
    send_op(CMD_COPY, 20, 5, 10, 0);
    send_op(CMD_READ, 25, 0, 0, 0);
    set_length(1);
    send_op(CMD_READ, 0, 0, 0, 0);
    send_op(CMD_READ, 1, 0, 0, 0);
    send_op(CMD_LOAD_SRC, 1, 0, 0, 32'h1234_5678);
    send_op(CMD_COPY, 0, 0, 1, 0);
    send_op(CMD_COPY, 0, 0, 2, 0);
    send_op(CMD_READ, 0, 0, 0, 0);

    // random phases over several lengths
    set_length(64);
    repeat (210) random_op();
    set_length($urandom_range(2, 63));
    steady = 1'b1;
    repeat (210) random_op();
    steady = 1'b0;
    set_length($urandom_range(2, 64));
    repeat (210) random_op();
    set_length(64);
    repeat (210) random_op();

    drain_inputs();
    if (fail_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
